// ===== sv/rffm_pkg.sv =====
package rffm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W = 4;
   localparam int ACC_W = 24;
   localparam int CW = 34;

   localparam logic [1:0] CSR_FEATURES = 2'd0;
   localparam logic [1:0] CSR_DIMS = 2'd1;
   localparam logic [1:0] CSR_SCALE = 2'd2;

   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh026DD3B6A;

   typedef struct packed {
      logic [ACC_W-1:0] phase;
   } job_type;

   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      case (i)
         4'd0: r = 32'h20000000;
         4'd1: r = 32'h12E4051E;
         4'd2: r = 32'h09FB385B;
         4'd3: r = 32'h051111D4;
         4'd4: r = 32'h028B0D43;
         4'd5: r = 32'h0145D7E1;
         4'd6: r = 32'h00A2F61E;
         4'd7: r = 32'h00517C55;
         4'd8: r = 32'h0028BE53;
         4'd9: r = 32'h00145F2F;
         4'd10: r = 32'h000A2F98;
         4'd11: r = 32'h000517CC;
         4'd12: r = 32'h00028BE6;
         4'd13: r = 32'h000145F3;
         4'd14: r = 32'h0000A2FA;
         default: r = 32'h0000517D;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] scale_sat(input logic signed [CW-1:0] v,
                                                    input logic [15:0] scale);
      logic signed [51:0] p;
      logic signed [51:0] q;
      p = 52'(v) * $signed({1'b0, scale}) + 52'sd134217728;
      q = p >>> 28;
      if (q > 52'sd32767) return 16'sd32767;
      if (q < -52'sd32768) return -16'sd32768;
      return q[15:0];
   endfunction

endpackage

// ===== sv/random_fourier_feature_map_core.sv =====
// Random Fourier feature map.
// Input queue (req_push/req_full): mode 0 words load one frequency entry,
// mode 1 words store one vector element. A mode 1 word with vector_end set
// starts the feature computation; the input stays full until the front end
// has handed the last phase to the back end.
// Result queue (rsp_empty/rsp_pop): D cosine words (slots 0..D-1) and then
// D sine words (slots D..2D-1), rsp_last set on the final one.
// Front end: one multiply-accumulate per cycle from the frequency memory,
// one feature phase at a time, handed over a one-entry queue.
// Back end: a 16-step CORDIC rotation per feature.
// A stalled receiver holds the current result word; the back end and then
// the front end stop until it is popped.
// Configuration (csr_valid/csr_ready, always ready) must be written idle.
// Reset restores D=16, dims=4, scale 1.0 and empties the pipeline; the
// stores hold no defined contents until written.
module random_fourier_feature_map_core
   import rffm_pkg::*;
#(
   parameter int MAX_FEATURES = 16,
   parameter int MAX_DIMS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_mode,
   input  logic [4:0]           req_feature_row,
   input  logic [2:0]           req_dim_index,
   input  logic signed [23:0]   req_frequency,
   input  logic signed [15:0]   req_sample,
   input  logic                 req_vector_end,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic signed [15:0]   rsp_feature_value,
   output logic [5:0]           rsp_feature_slot,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data
);
   logic [5:0] feat_ff;
   logic [3:0] dims_ff;
   logic [15:0] scale_ff;
   logic [5:0] nf;
   logic [3:0] nd;
   logic in_ready, job_valid, job_ready, out_valid;
   job_type job;

   assign csr_ready = 1'b1;
   assign nf = (feat_ff == '0) ? 6'd1 :
               (feat_ff > 6'(MAX_FEATURES)) ? 6'(MAX_FEATURES) : feat_ff;
   assign nd = (dims_ff == '0) ? 4'd1 :
               (dims_ff > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dims_ff;
   assign req_full = !in_ready;
   assign rsp_empty = !out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         feat_ff <= 6'd16;
         dims_ff <= 4'd4;
         scale_ff <= 16'd4096;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FEATURES: feat_ff <= csr_data[5:0];
            CSR_DIMS: dims_ff <= csr_data[3:0];
            CSR_SCALE: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rffm_front #(.MAX_FEATURES(MAX_FEATURES), .MAX_DIMS(MAX_DIMS)) u_front (
      .clock, .reset,
      .in_valid(req_push), .in_ready,
      .mode(req_mode), .feature_row(req_feature_row), .dim_index(req_dim_index),
      .frequency(req_frequency), .sample(req_sample), .vector_end(req_vector_end),
      .nf, .nd, .job_valid, .job_ready, .job
   );

   rffm_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job, .nf, .scale(scale_ff),
      .out_valid, .out_pop(rsp_pop), .out_value(rsp_feature_value),
      .out_slot(rsp_feature_slot), .out_last(rsp_last)
   );
endmodule

// ===== sv/rffm_front.sv =====
module rffm_front
   import rffm_pkg::*;
#(
   parameter int MAX_FEATURES = 16,
   parameter int MAX_DIMS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 mode,
   input  logic [4:0]           feature_row,
   input  logic [2:0]           dim_index,
   input  logic signed [23:0]   frequency,
   input  logic signed [15:0]   sample,
   input  logic                 vector_end,
   input  logic [5:0]           nf,
   input  logic [3:0]           nd,
   output logic                 job_valid,
   input  logic                 job_ready,
   output job_type              job
);
   localparam int FD = MAX_FEATURES * MAX_DIMS;
   localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
   localparam int RW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_RUN  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   logic signed [23:0] freq_mem [FD];
   logic signed [15:0] samp_ff [MAX_DIMS];
   fstate_type state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [DW-1:0] dim_ff, dim_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic signed [23:0] fq_ff;
   logic signed [15:0] sp_ff;
   logic rd_ok_ff, rd_ok_in;
   logic rd_last_ff, rd_last_in;
   logic rd_ff, rd_in;
   logic [FAW-1:0] rd_addr;
   logic signed [39:0] prod;
   logic [RW-1:0] last_row;
   logic [DW-1:0] last_dim;
   logic take;

   assign last_row = RW'(nf - 6'd1);
   assign last_dim = DW'(nd - 4'd1);
   assign in_ready = (state_ff == F_IDLE);
   assign take = in_valid && in_ready;
   assign rd_addr = FAW'(row_ff * MAX_DIMS + dim_ff);
   assign prod = fq_ff * sp_ff;
   assign job_valid = (state_ff == F_PUSH);
   assign job.phase = acc_ff;

   always_ff @(posedge clock) begin
      if (take && !mode && feature_row < MAX_FEATURES && dim_index < MAX_DIMS) begin
         freq_mem[FAW'(feature_row * MAX_DIMS + dim_index)] <= frequency;
      end
      if (take && mode && dim_index < MAX_DIMS) begin
         samp_ff[DW'(dim_index)] <= sample;
      end
      fq_ff <= freq_mem[rd_addr];
      sp_ff <= samp_ff[dim_ff];
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      dim_in = dim_ff;
      acc_in = acc_ff;
      rd_in = 1'b0;
      rd_ok_in = 1'b0;
      rd_last_in = 1'b0;
      if (rd_ok_ff) begin
         acc_in = acc_ff + prod[ACC_W-1:0];
      end
      unique case (state_ff)
         F_IDLE: begin
            if (take && mode && vector_end) begin
               state_in = F_RUN;
               row_in = '0;
               dim_in = '0;
               acc_in = '0;
               rd_in = 1'b1;
            end
         end
         F_RUN: begin
            if (rd_ff) begin
               rd_ok_in = 1'b1;
               if (dim_ff == last_dim) begin
                  rd_last_in = 1'b1;
               end else begin
                  dim_in = dim_ff + 1'b1;
                  rd_in = 1'b1;
               end
            end else if (rd_last_ff) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (job_ready) begin
               acc_in = '0;
               dim_in = '0;
               if (row_ff == last_row) begin
                  state_in = F_IDLE;
               end else begin
                  row_in = row_ff + 1'b1;
                  rd_in = 1'b1;
                  state_in = F_RUN;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         rd_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_ff <= rd_in;
         rd_ok_ff <= rd_ok_in;
         rd_last_ff <= rd_last_in;
      end
      row_ff <= row_in;
      dim_ff <= dim_in;
      acc_ff <= acc_in;
   end

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != F_IDLE) |-> !in_ready)
      else $error("front accepted a word while busy");
   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      (job_valid && !job_ready) |=> (job_valid && $stable(acc_ff)))
      else $error("queued phase changed while stalled");
   a_rd_pipe: assert property (@(posedge clock) disable iff (reset)
      rd_ff |=> rd_ok_ff)
      else $error("memory read lost");
`endif
endmodule

// ===== sv/rffm_back.sv =====
module rffm_back
   import rffm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  job_type              job,
   input  logic [5:0]           nf,
   input  logic [15:0]          scale,
   output logic                 out_valid,
   input  logic                 out_pop,
   output logic signed [15:0]   out_value,
   output logic [5:0]           out_slot,
   output logic                 out_last
);
   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_ROT  = 4'b0010,
      B_COS  = 4'b0100,
      B_SIN  = 4'b1000
   } bstate_type;

   localparam int SW = 16;

   bstate_type state_ff, state_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [5:0] k_ff, k_in;
   logic signed [SW-1:0] sin_ff;
   logic signed [SW-1:0] sin_now;
   logic valid_ff, valid_in;
   logic signed [SW-1:0] val_ff, val_in;
   logic [5:0] slot_ff, slot_in;
   logic last_ff, last_in;
   logic signed [CW-1:0] c_v, s_v, at;
   logic room;

   assign room = !valid_ff || out_pop;
   assign job_ready = (state_ff == B_IDLE);
   assign out_valid = valid_ff;
   assign out_value = val_ff;
   assign out_slot = slot_ff;
   assign out_last = last_ff;
   assign at = $signed({2'b00, atan_turn(step_ff)});
   assign sin_now = scale_sat(s_v, scale);

   always_comb begin
      unique case (q_ff)
         2'd0: begin c_v = x_ff; s_v = y_ff; end
         2'd1: begin c_v = -y_ff; s_v = x_ff; end
         2'd2: begin c_v = -x_ff; s_v = -y_ff; end
         default: begin c_v = y_ff; s_v = -x_ff; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; q_in = q_ff;
      step_in = step_ff; k_in = k_ff;
      valid_in = valid_ff && !out_pop;
      val_in = val_ff; slot_in = slot_ff; last_in = last_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               q_in = job.phase[ACC_W-1 -: 2];
               z_in = $signed({4'b0000, job.phase[ACC_W-3:0], 8'h00});
               x_in = CORDIC_X0;
               y_in = '0;
               step_in = '0;
               state_in = B_ROT;
            end
         end
         B_ROT: begin
            if (!z_ff[CW-1]) begin
               x_in = x_ff - (y_ff >>> step_ff);
               y_in = y_ff + (x_ff >>> step_ff);
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + (y_ff >>> step_ff);
               y_in = y_ff - (x_ff >>> step_ff);
               z_in = z_ff + at;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = B_COS;
            end
         end
         B_COS: begin
            if (room) begin
               valid_in = 1'b1;
               val_in = scale_sat(c_v, scale);
               slot_in = k_ff;
               last_in = 1'b0;
               if (k_ff == nf - 6'd1) begin
                  k_in = '0;
                  state_in = B_SIN;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = B_IDLE;
               end
            end
         end
         B_SIN: begin
            if (room) begin
               valid_in = 1'b1;
               val_in = sin_ff;
               slot_in = nf + k_ff;
               last_in = (k_ff == nf - 6'd1);
               if (k_ff == nf - 6'd1) begin
                  k_in = '0;
                  state_in = B_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Sines are replayed from a small store after all cosines have left.
   logic signed [SW-1:0] sin_mem [32];
   always_ff @(posedge clock) begin
      if (state_ff == B_COS && room) begin
         sin_mem[k_ff[4:0]] <= sin_now;
      end
      if (state_ff == B_COS && room && k_in == k_ff) begin
         sin_ff <= sin_now;
      end else begin
         sin_ff <= sin_mem[k_in[4:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         k_ff <= k_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; q_ff <= q_in;
      step_ff <= step_in;
      val_ff <= val_in; slot_ff <= slot_in; last_ff <= last_in;
   end

`ifndef SYNTHESIS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_pop) |=> (valid_ff && $stable(val_ff) && $stable(slot_ff)))
      else $error("result word changed while stalled");
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (slot_ff == 6'(2 * nf - 6'd1)))
      else $error("last flag on wrong slot");
   a_rot_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE && job_valid) |=> (state_ff == B_ROT && step_ff == '0))
      else $error("rotation did not start cleanly");
`endif
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import rffm_pkg::*;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int N_ROWS = 16;
   localparam int N_DIMS = 4;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic        mode;
      logic [4:0]  row;
      logic [2:0]  dim;
      logic [23:0] freq;
      logic [15:0] smp;
      logic        vend;
   } word_type;

   typedef struct {
      logic [15:0] value;
      logic [5:0]  slot;
      logic        last;
   } feature_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_mode = 1'b0;
   logic [4:0] req_feature_row = '0;
   logic [2:0] req_dim_index = '0;
   logic signed [23:0] req_frequency = '0;
   logic signed [15:0] req_sample = '0;
   logic req_vector_end = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [15:0] rsp_feature_value;
   logic [5:0] rsp_feature_slot;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   word_type pending_words[$];
   feature_type expected_features[$];
   logic signed [23:0] freq_table[N_ROWS*N_DIMS];
   logic signed [15:0] sample_store[N_DIMS];
   logic [5:0] features_reg = 6'd16;
   logic [3:0] dims_reg = 4'd4;
   logic [15:0] scale_reg = 16'd4096;
   int fails = 0;
   int cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   random_fourier_feature_map_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   localparam longint ATAN_TURNS[16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

   function automatic logic [15:0] scaled(input longint v, input logic [15:0] sc);
      longint p;
      p = (v * longint'({48'd0, sc}) + (64'sd1 <<< 27)) >>> 28;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return p[15:0];
   endfunction

   task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 64'h26DD3B6A;
      y = 0;
      z = longint'({34'd0, ang[29:0]});
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TURNS[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TURNS[i];
         end
      end
      case (ang[31:30])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic predict_features(input word_type w);
      int nf, nd;
      longint acc, c, s;
      logic [31:0] ang;
      feature_type f;
      if (w.mode == MODE_LOAD) begin
         if (w.row < N_ROWS && w.dim < N_DIMS) freq_table[w.row*N_DIMS + w.dim] = w.freq;
         return;
      end
      if (w.dim < N_DIMS) sample_store[w.dim] = w.smp;
      if (!w.vend) return;
      nf = (features_reg == 0) ? 1 : (features_reg > N_ROWS) ? N_ROWS : features_reg;
      nd = (dims_reg == 0) ? 1 : (dims_reg > N_DIMS) ? N_DIMS : dims_reg;
      for (int pass = 0; pass < 2; pass++) begin
         for (int k = 0; k < nf; k++) begin
            acc = 0;
            for (int d = 0; d < nd; d++)
               acc += longint'(freq_table[k*N_DIMS + d]) * longint'(sample_store[d]);
            ang = {acc[23:0], 8'd0};
            rotate(ang, c, s);
            f.value = scaled(pass == 0 ? c : s, scale_reg);
            f.slot = 6'(pass*nf + k);
            f.last = (pass == 1 && k == nf - 1);
            expected_features.push_back(f);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_features(pending_words.pop_front());
         end
         if (req_push && req_full) begin
            req_push <= 1'b1;
         end else if (gap_left > 0 || pending_words.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_push <= 1'b0;
         end else begin
            req_push <= 1'b1;
            req_mode <= pending_words[0].mode;
            req_feature_row <= pending_words[0].row;
            req_dim_index <= pending_words[0].dim;
            req_frequency <= pending_words[0].freq;
            req_sample <= pending_words[0].smp;
            req_vector_end <= pending_words[0].vend;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_features.size() == 0) begin
               $error("unexpected word: value %0d slot %0d", rsp_feature_value,
                      rsp_feature_slot);
               fails++;
            end else begin
               if (rsp_feature_value !== expected_features[0].value) begin
                  $error("feature_value: expected %0d, actual %0d",
                         $signed(expected_features[0].value), rsp_feature_value);
                  fails++;
               end
               if (rsp_feature_slot !== expected_features[0].slot) begin
                  $error("feature_slot: expected %0d, actual %0d",
                         expected_features[0].slot, rsp_feature_slot);
                  fails++;
               end
               if (rsp_last !== expected_features[0].last) begin
                  $error("last: expected %0d, actual %0d", expected_features[0].last,
                         rsp_last);
                  fails++;
               end
               void'(expected_features.pop_front());
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 700;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_mode == 0) begin
            rsp_pop <= 1'b1;
         end else if (stall_mode == 1) begin
            rsp_pop <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_pop <= ((cycles % 7) < 3);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic word_type make_word(input logic mode, input logic [4:0] row,
                                          input logic [2:0] dim, input logic [23:0] freq,
                                          input logic [15:0] smp, input logic vend);
      word_type w;
      w.mode = mode; w.row = row; w.dim = dim; w.freq = freq; w.smp = smp; w.vend = vend;
      return w;
   endfunction

   task automatic add_vector(input int nd);
      for (int d = 0; d < nd; d++)
         pending_words.push_back(make_word(MODE_SAMPLE, 5'($urandom), 3'(d), 24'($urandom),
                                           16'($urandom), d == nd - 1));
   endtask

   task automatic add_random(input int count);
      int nd;
      int pick;
      nd = (dims_reg == 0) ? 1 : (dims_reg > N_DIMS) ? N_DIMS : dims_reg;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            add_vector(nd);
         end else if (pick < 9) begin
            pending_words.push_back(make_word(MODE_LOAD, 5'($urandom), 3'($urandom),
                                              24'($urandom), 16'($urandom), 1'($urandom)));
         end else begin
            pending_words.push_back(make_word(MODE_SAMPLE, 5'($urandom), 3'($urandom),
                                              24'($urandom), 16'($urandom), 1'($urandom)));
         end
      end
   endtask

   task automatic wait_idle;
      while (pending_words.size() != 0 || expected_features.size() != 0 || req_push)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FEATURES: features_reg = data[5:0];
         CSR_DIMS: dims_reg = data[3:0];
         CSR_SCALE: scale_reg = data;
         default: ;
      endcase
   endtask

   task automatic run_phase(input logic [15:0] nf, input logic [15:0] nd,
                            input logic [15:0] sc, input int count, input int stall);
      wait_idle();
      write_csr(CSR_FEATURES, nf);
      write_csr(CSR_DIMS, nd);
      write_csr(CSR_SCALE, sc);
      stall_mode = stall;
      add_random(count);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_ROWS; r++)
         for (int d = 0; d < N_DIMS; d++)
            pending_words.push_back(make_word(MODE_LOAD, 5'(r), 3'(d), 24'($urandom),
                                              16'($urandom), 1'b0));
      pending_words.push_back(make_word(MODE_LOAD, 5'd0, 3'd0, 24'h800000, 16'h0, 1'b0));
      pending_words.push_back(make_word(MODE_LOAD, 5'd1, 3'd1, 24'h7FFFFF, 16'h0, 1'b0));
      pending_words.push_back(make_word(MODE_LOAD, 5'd31, 3'd7, 24'h123456, 16'h0, 1'b1));
      pending_words.push_back(make_word(MODE_LOAD, 5'd2, 3'd5, 24'h654321, 16'h0, 1'b0));
      pending_words.push_back(make_word(MODE_SAMPLE, 5'd31, 3'd0, 24'hFFFFFF, 16'h8000, 1'b0));
      pending_words.push_back(make_word(MODE_SAMPLE, 5'd0, 3'd1, 24'h0, 16'h7FFF, 1'b0));
      pending_words.push_back(make_word(MODE_SAMPLE, 5'd0, 3'd2, 24'h0, 16'h0000, 1'b0));
      pending_words.push_back(make_word(MODE_SAMPLE, 5'd0, 3'd3, 24'h0, 16'hFFFF, 1'b1));
      pending_words.push_back(make_word(MODE_SAMPLE, 5'd0, 3'd7, 24'h0, 16'h1234, 1'b1));
      pending_words.push_back(make_word(MODE_SAMPLE, 5'd0, 3'd0, 24'h0, 16'h0100, 1'b1));
      wait_idle();
      write_csr(CSR_SPARE, 16'hFFFF);
      write_csr(CSR_SCALE, 16'hFFFF);
      pending_words.push_back(make_word(MODE_SAMPLE, 5'd0, 3'd1, 24'h0, 16'h8000, 1'b1));

      run_phase(16'd1, 16'd1, 16'd65535, 15, 1);
      run_phase(16'd16, 16'd4, 16'd4096, 10, 0);
      hold_request = 1'b1;
      run_phase(16'd0, 16'd0, 16'd0, 15, 2);
      run_phase(16'd32, 16'd8, 16'd30000, 8, 1);
      run_phase(16'd63, 16'd15, 16'($urandom), 8, 2);
      run_phase(16'd5, 16'd2, 16'd2896, 14, 1);
      wait_idle();

      if (fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== random_fourier_feature_map_core.f =====
sv/rffm_pkg.sv
sv/rffm_front.sv
sv/rffm_back.sv
sv/random_fourier_feature_map_core.sv
sim/tb_top.sv
